[design/xgrd_pkg.sv]
// package for the gamepad report decoder: report layout constants,
// configuration register indexes, button positions and the analog scaling function
// no dependencies
package xgrd_pkg;

    localparam int REPORT_BYTES      = 20;
    localparam int EXTRA_BUTTON_BASE = 11;
    localparam int REPORT_W          = 8 * REPORT_BYTES;
    localparam int LEN_W             = 6;
    localparam int CFG_IDX_W         = 3;
    localparam int CFG_DATA_W        = 8;
    localparam int AXIS_W            = 16;
    localparam int NUM_AXES          = 12;
    localparam int FACE_COUNT        = 6;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAMEPAD_KIND    = 3'd0,
        CFG_DANCE_MODE      = 3'd1,
        CFG_LIGHT_GUN_MODE  = 3'd2,
        CFG_NULL_STICKS     = 3'd3,
        CFG_PRESS_THRESHOLD = 3'd4
    } t_cfg_idx;

    // report byte positions
    localparam int BYTE_DIGITAL = 2;
    localparam int BYTE_GUN     = 3;
    localparam int BYTE_LTRIG   = 10;
    localparam int BYTE_RTRIG   = 11;
    localparam int BYTE_LX      = 12;
    localparam int BYTE_LY      = 14;
    localparam int BYTE_RX      = 16;
    localparam int BYTE_RY      = 18;

    // digital byte bits
    localparam int DIG_START = 4;
    localparam int DIG_BACK  = 5;
    localparam int DIG_LCLK  = 6;
    localparam int DIG_RCLK  = 7;
    localparam int GUN_BIT   = 5;

    // button positions
    localparam int BTN_BACK  = 4;
    localparam int BTN_START = 6;
    localparam int BTN_LCLK  = 7;
    localparam int BTN_RCLK  = 8;

    // face bytes A, B, X, Y, White, Black
    localparam logic [4:0] FACE_OFFSET [FACE_COUNT] = '{5'd4, 5'd5, 5'd6, 5'd7, 5'd9, 5'd8};
    localparam logic [3:0] FACE_BUTTON [FACE_COUNT] = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd9, 4'd10};

    localparam logic [3:0] HAT_UP    = 4'h1;
    localparam logic [3:0] HAT_RIGHT = 4'h2;
    localparam logic [3:0] HAT_DOWN  = 4'h4;
    localparam logic [3:0] HAT_LEFT  = 4'h8;

    // v*257 - 32768 modulo 2^16 is the byte repeated with the top bit flipped
    function automatic logic [AXIS_W-1:0] scale_byte(input logic [7:0] v);
        return {~v[7], v[6:0], v};
    endfunction

endpackage

[design/xid_gamepad_report_decoder.sv]
// top level of the gamepad report decoder: input register, decode logic,
// result register and configuration registers
// depends on xgrd_pkg
//
// an accepted item passes the input register and then the result register
// throughput: one item per cycle while results are taken; while the result waits the input register takes one more item
// reset: synchronous active-low, clears both valid flags and returns the configuration
// registers to gamepad kind set, all modes off and threshold 32
module xid_gamepad_report_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [xgrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [xgrd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [63:0]                         i_bytes_low,
    input  logic [63:0]                         i_bytes_mid,
    input  logic [31:0]                         i_bytes_high,
    input  logic [xgrd_pkg::LEN_W-1:0]          i_report_length,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_ok,
    output logic [15:0]                         o_button_bits,
    output logic [3:0]                          o_hat_bits,
    output logic [63:0]                         o_axes_first,
    output logic [63:0]                         o_axes_second,
    output logic [63:0]                         o_axes_third
);

    logic                                r_gamepad_kind;
    logic                                r_dance_mode;
    logic                                r_light_gun_mode;
    logic                                r_null_sticks;
    logic [xgrd_pkg::CFG_DATA_W-1:0]     r_press_threshold;

    logic                                r_s1_valid;
    logic [xgrd_pkg::REPORT_W-1:0]       r_bytes;
    logic [xgrd_pkg::LEN_W-1:0]          r_len;

    logic                                r_out_valid;
    logic                                s1_load;
    logic                                out_load;

    logic                                n_ok;
    logic [15:0]                         n_button_bits;
    logic [3:0]                          n_hat_bits;
    logic [63:0]                         n_axes_first;
    logic [63:0]                         n_axes_second;
    logic [63:0]                         n_axes_third;

    assign o_in_ready  = !r_s1_valid || !r_out_valid || i_out_ready;
    assign s1_load     = i_in_valid && o_in_ready;
    assign out_load    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gamepad_kind    <= 1'b1;
            r_dance_mode      <= 1'b0;
            r_light_gun_mode  <= 1'b0;
            r_null_sticks     <= 1'b0;
            r_press_threshold <= xgrd_pkg::THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                xgrd_pkg::CFG_GAMEPAD_KIND:    r_gamepad_kind    <= i_cfg_data[0];
                xgrd_pkg::CFG_DANCE_MODE:      r_dance_mode      <= i_cfg_data[0];
                xgrd_pkg::CFG_LIGHT_GUN_MODE:  r_light_gun_mode  <= i_cfg_data[0];
                xgrd_pkg::CFG_NULL_STICKS:     r_null_sticks     <= i_cfg_data[0];
                xgrd_pkg::CFG_PRESS_THRESHOLD: r_press_threshold <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (out_load) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_bytes <= {i_bytes_high, i_bytes_mid, i_bytes_low};
            r_len   <= i_report_length;
        end
    end

    // decode
    always_comb begin
        logic [7:0]  digital;
        logic [7:0]  face;
        logic [15:0] buttons;
        logic [3:0]  hat;
        logic [xgrd_pkg::AXIS_W-1:0] axis [xgrd_pkg::NUM_AXES];
        logic        accept;

        accept = r_gamepad_kind
              && (r_len >= xgrd_pkg::LEN_W'(xgrd_pkg::REPORT_BYTES))
              && (r_bytes[7:0] == 8'd0)
              && (r_bytes[15:8] == 8'(xgrd_pkg::REPORT_BYTES));

        digital = r_bytes[8*xgrd_pkg::BYTE_DIGITAL +: 8];
        buttons = '0;
        hat     = '0;
        for (int i = 0; i < xgrd_pkg::NUM_AXES; i++) begin
            axis[i] = '0;
        end

        buttons[xgrd_pkg::BTN_BACK]  = digital[xgrd_pkg::DIG_BACK];
        buttons[xgrd_pkg::BTN_START] = digital[xgrd_pkg::DIG_START];
        buttons[xgrd_pkg::BTN_LCLK]  = digital[xgrd_pkg::DIG_LCLK];
        buttons[xgrd_pkg::BTN_RCLK]  = digital[xgrd_pkg::DIG_RCLK];

        for (int i = 0; i < xgrd_pkg::FACE_COUNT; i++) begin
            face = r_bytes[8*xgrd_pkg::FACE_OFFSET[i] +: 8];
            if (face > r_press_threshold) begin
                buttons[xgrd_pkg::FACE_BUTTON[i]] = 1'b1;
            end
            axis[6 + i] = xgrd_pkg::scale_byte(face);
        end

        if (r_dance_mode) begin
            for (int i = 0; i < 4; i++) begin
                if (digital[i]) begin
                    buttons[4'(xgrd_pkg::EXTRA_BUTTON_BASE + i)] = 1'b1;
                end
            end
        end else begin
            // opposite directions cancel
            if (digital[1:0] == 2'b01) hat = hat | xgrd_pkg::HAT_UP;
            if (digital[1:0] == 2'b10) hat = hat | xgrd_pkg::HAT_DOWN;
            if (digital[3:2] == 2'b01) hat = hat | xgrd_pkg::HAT_LEFT;
            if (digital[3:2] == 2'b10) hat = hat | xgrd_pkg::HAT_RIGHT;
        end

        if (r_light_gun_mode && r_bytes[8*xgrd_pkg::BYTE_GUN + xgrd_pkg::GUN_BIT]) begin
            buttons[4'(xgrd_pkg::EXTRA_BUTTON_BASE)] = 1'b1;
        end

        if (!r_null_sticks) begin
            axis[0] =  r_bytes[8*xgrd_pkg::BYTE_LX +: 16];
            axis[1] = ~r_bytes[8*xgrd_pkg::BYTE_LY +: 16];
            axis[2] =  r_bytes[8*xgrd_pkg::BYTE_RX +: 16];
            axis[3] = ~r_bytes[8*xgrd_pkg::BYTE_RY +: 16];
        end
        axis[4] = xgrd_pkg::scale_byte(r_bytes[8*xgrd_pkg::BYTE_LTRIG +: 8]);
        axis[5] = xgrd_pkg::scale_byte(r_bytes[8*xgrd_pkg::BYTE_RTRIG +: 8]);

        for (int i = 0; i < 4; i++) begin
            n_axes_first[16*i +: 16]  = axis[i];
            n_axes_second[16*i +: 16] = axis[4 + i];
            n_axes_third[16*i +: 16]  = axis[8 + i];
        end

        n_ok          = accept;
        n_button_bits = buttons;
        n_hat_bits    = hat;
        if (!accept) begin
            n_button_bits = '0;
            n_hat_bits    = '0;
            n_axes_first  = '0;
            n_axes_second = '0;
            n_axes_third  = '0;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_ok          <= n_ok;
            o_button_bits <= n_button_bits;
            o_hat_bits    <= n_hat_bits;
            o_axes_first  <= n_axes_first;
            o_axes_second <= n_axes_second;
            o_axes_third  <= n_axes_third;
        end
    end

endmodule

[design/xgrd_checker.sv]
// port-level checks for the gamepad report decoder, bound to the top level
// depends on xid_gamepad_report_decoder
module xgrd_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_ready,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic                                o_ok,
    input  logic [15:0]                         o_button_bits,
    input  logic [3:0]                          o_hat_bits,
    input  logic [63:0]                         o_axes_first,
    input  logic [63:0]                         o_axes_second,
    input  logic [63:0]                         o_axes_third
);

    // a rejected report carries nothing but ok=0
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> (o_button_bits == '0) && (o_hat_bits == '0)
            && (o_axes_first == '0) && (o_axes_second == '0) && (o_axes_third == '0))
        else $error("rejected report with nonzero fields");

    // opposite hat directions never show together
    a_hat_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hat_bits[0] && o_hat_bits[2]) && !(o_hat_bits[1] && o_hat_bits[3]))
        else $error("hat shows opposite directions");

    // an accepted item is followed by a valid result at the output
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 o_out_valid)
        else $error("accepted item produced no result");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid && $stable(o_ok)
            && $stable(o_button_bits) && $stable(o_hat_bits) && $stable(o_axes_first)
            && $stable(o_axes_second) && $stable(o_axes_third))
        else $error("stalled result changed");

endmodule

bind xid_gamepad_report_decoder xgrd_checker u_xgrd_checker (.*);

[bench/tb.sv]
// self-checking bench for the gamepad report decoder: directed table, then random reports
// under several register settings, every result checked against a literal expectation or an in-bench decode model
// depends on xgrd_pkg and xid_gamepad_report_decoder
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xgrd_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 6;
    localparam int SETUP_COUNT      = 8;
    localparam int RANDOM_PER_SETUP = 210;
    localparam int MAX_LEN          = (1 << LEN_W) - 1;

    typedef struct packed {
        logic        ok;
        logic [15:0] button_bits;
        logic [3:0]  hat_bits;
        logic [63:0] axes_first;
        logic [63:0] axes_second;
        logic [63:0] axes_third;
    } report_result_t;

    typedef struct {
        logic [63:0]    lo;
        logic [63:0]    mid;
        logic [31:0]    hi;
        logic [5:0]     len;
        bit             known;
        report_result_t want;
    } report_row_t;

    typedef struct packed {
        logic       kind;
        logic       dance;
        logic       gun;
        logic       sticks_off;
        logic [7:0] threshold;
    } decode_setup_t;

    localparam report_result_t REJECTED = '0;
    // header only: sticks read as zero, so the inverted Y axes are all ones
    localparam report_result_t BLANK_REPORT = '{
        ok: 1'b1, button_bits: 16'h0000, hat_bits: 4'h0,
        axes_first: 64'hFFFF_0000_FFFF_0000,
        axes_second: 64'h8000_8000_8000_8000,
        axes_third: 64'h8000_8000_8000_8000};
    // every payload byte 0xff, long transfer
    localparam report_result_t FULL_REPORT = '{
        ok: 1'b1, button_bits: 16'h07DF, hat_bits: 4'h0,
        axes_first: 64'h0000_FFFF_0000_FFFF,
        axes_second: 64'h7FFF_7FFF_7FFF_7FFF,
        axes_third: 64'h7FFF_7FFF_7FFF_7FFF};

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [63:0] i_bytes_low = '0;
    logic [63:0] i_bytes_mid = '0;
    logic [31:0] i_bytes_high = '0;
    logic [LEN_W-1:0] i_report_length = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_ok;
    logic [15:0] o_button_bits;
    logic [3:0]  o_hat_bits;
    logic [63:0] o_axes_first;
    logic [63:0] o_axes_second;
    logic [63:0] o_axes_third;

    // decoder settings as the bench believes them
    logic       cfg_kind = 1'b1;
    logic       cfg_dance = 1'b0;
    logic       cfg_gun = 1'b0;
    logic       cfg_sticks_off = 1'b0;
    logic [7:0] cfg_threshold = 8'd32;

    // a literal expectation travels with the item it belongs to
    bit             pinned_known = 1'b0;
    report_result_t pinned_want = '0;

    report_result_t expected_reports [$];
    bit steady_flow = 1'b0;
    int n_fail = 0;
    int cycle_count = 0;
    int sink_hold = 0;
    int sink_draw;

    xid_gamepad_report_decoder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_bytes_low     (i_bytes_low),
        .i_bytes_mid     (i_bytes_mid),
        .i_bytes_high    (i_bytes_high),
        .i_report_length (i_report_length),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_ok            (o_ok),
        .o_button_bits   (o_button_bits),
        .o_hat_bits      (o_hat_bits),
        .o_axes_first    (o_axes_first),
        .o_axes_second   (o_axes_second),
        .o_axes_third    (o_axes_third)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] scaled_axis(input logic [7:0] v);
        return 16'(int'(v) * 257 - 32768);
    endfunction

    function automatic report_result_t decode_report(input logic [63:0] lo, input logic [63:0] mid,
                                                     input logic [31:0] hi, input logic [5:0] len);
        logic [8*REPORT_BYTES-1:0] rep;
        logic [7:0] rb [REPORT_BYTES];
        logic [7:0] dig;
        logic [15:0] lx, ly, rx, ry;
        report_result_t r;
        int k;
        rep = {hi, mid, lo};
        for (k = 0; k < REPORT_BYTES; k++)
            rb[k] = rep[8*k +: 8];
        r = '0;
        if (!cfg_kind || len < REPORT_BYTES || rb[0] != 8'd0 || rb[1] != 8'(REPORT_BYTES))
            return r;

        r.ok = 1'b1;
        dig = rb[BYTE_DIGITAL];
        r.button_bits[BTN_BACK]  = dig[DIG_BACK];
        r.button_bits[BTN_START] = dig[DIG_START];
        r.button_bits[BTN_LCLK]  = dig[DIG_LCLK];
        r.button_bits[BTN_RCLK]  = dig[DIG_RCLK];

        // face bytes: A 4, B 5, X 6, Y 7, black 8, white 9
        r.button_bits[0]  = rb[4] > cfg_threshold;
        r.button_bits[1]  = rb[5] > cfg_threshold;
        r.button_bits[2]  = rb[6] > cfg_threshold;
        r.button_bits[3]  = rb[7] > cfg_threshold;
        r.button_bits[9]  = rb[9] > cfg_threshold;
        r.button_bits[10] = rb[8] > cfg_threshold;

        if (cfg_dance) begin
            for (k = 0; k < 4; k++)
                if (dig[k])
                    r.button_bits[EXTRA_BUTTON_BASE + k] = 1'b1;
        end else begin
            // opposite directions held together cancel
            if (dig[1:0] == 2'b01) r.hat_bits |= HAT_UP;
            if (dig[1:0] == 2'b10) r.hat_bits |= HAT_DOWN;
            if (dig[3:2] == 2'b01) r.hat_bits |= HAT_LEFT;
            if (dig[3:2] == 2'b10) r.hat_bits |= HAT_RIGHT;
        end

        if (cfg_gun && rb[BYTE_GUN][GUN_BIT])
            r.button_bits[EXTRA_BUTTON_BASE] = 1'b1;

        if (!cfg_sticks_off) begin
            lx = {rb[BYTE_LX + 1], rb[BYTE_LX]};
            ly = ~{rb[BYTE_LY + 1], rb[BYTE_LY]};
            rx = {rb[BYTE_RX + 1], rb[BYTE_RX]};
            ry = ~{rb[BYTE_RY + 1], rb[BYTE_RY]};
            r.axes_first = {ry, rx, ly, lx};
        end
        r.axes_second = {scaled_axis(rb[5]), scaled_axis(rb[4]),
                         scaled_axis(rb[BYTE_RTRIG]), scaled_axis(rb[BYTE_LTRIG])};
        r.axes_third  = {scaled_axis(rb[8]), scaled_axis(rb[9]),
                         scaled_axis(rb[7]), scaled_axis(rb[6])};
        return r;
    endfunction

    // result side: after each item taken, ready is held low on a random draw, except in steady flow
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold   <= sink_hold - 1;
            i_out_ready <= (sink_hold == 1);
        end else if (o_out_valid && i_out_ready) begin
            sink_draw = steady_flow ? 0 : $urandom_range(0, 4);
            sink_hold   <= sink_draw;
            i_out_ready <= (sink_draw == 0);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        report_result_t want;
        if (o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                $error("result with no report outstanding");
                n_fail++;
            end else begin
                want = expected_reports.pop_front();
                if (o_ok !== want.ok) begin
                    $error("ok: expected %h, got %h", want.ok, o_ok);
                    n_fail++;
                end
                if (o_button_bits !== want.button_bits) begin
                    $error("button_bits: expected %h, got %h", want.button_bits, o_button_bits);
                    n_fail++;
                end
                if (o_hat_bits !== want.hat_bits) begin
                    $error("hat_bits: expected %h, got %h", want.hat_bits, o_hat_bits);
                    n_fail++;
                end
                if (o_axes_first !== want.axes_first) begin
                    $error("axes_first: expected %h, got %h", want.axes_first, o_axes_first);
                    n_fail++;
                end
                if (o_axes_second !== want.axes_second) begin
                    $error("axes_second: expected %h, got %h", want.axes_second, o_axes_second);
                    n_fail++;
                end
                if (o_axes_third !== want.axes_third) begin
                    $error("axes_third: expected %h, got %h", want.axes_third, o_axes_third);
                    n_fail++;
                end
            end
        end
        if (i_in_valid && o_in_ready)
            expected_reports.push_back(pinned_known ? pinned_want :
                decode_report(i_bytes_low, i_bytes_mid, i_bytes_high, i_report_length));
    end

    // returns at the edge that takes the item, valid still high
    task automatic send_report(input logic [63:0] lo, input logic [63:0] mid,
                               input logic [31:0] hi, input logic [5:0] len,
                               input bit known, input report_result_t want);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_bytes_low     <= lo;
        i_bytes_mid     <= mid;
        i_bytes_high    <= hi;
        i_report_length <= len;
        pinned_known    <= known;
        pinned_want     <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GAMEPAD_KIND:    cfg_kind       = data[0];
            CFG_DANCE_MODE:      cfg_dance      = data[0];
            CFG_LIGHT_GUN_MODE:  cfg_gun        = data[0];
            CFG_NULL_STICKS:     cfg_sticks_off = data[0];
            CFG_PRESS_THRESHOLD: cfg_threshold  = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // single-bit registers get junk in the upper bits, which must be dropped
    task automatic apply_setup(input decode_setup_t s);
        logic [CFG_IDX_W-1:0] spare;
        spare = CFG_IDX_W'($urandom_range(int'(CFG_PRESS_THRESHOLD) + 1, (1 << CFG_IDX_W) - 1));
        cfg_write(spare, CFG_DATA_W'($urandom));
        cfg_write(CFG_GAMEPAD_KIND,    {7'($urandom), s.kind});
        cfg_write(CFG_DANCE_MODE,      {7'($urandom), s.dance});
        cfg_write(CFG_LIGHT_GUN_MODE,  {7'($urandom), s.gun});
        cfg_write(CFG_NULL_STICKS,     {7'($urandom), s.sticks_off});
        cfg_write(CFG_PRESS_THRESHOLD, s.threshold);
    endtask

    task automatic random_reports(input int count);
        logic [63:0] lo, mid;
        logic [31:0] hi;
        logic [5:0]  len;
        int pick, k;
        repeat (count) begin
            lo   = {$urandom, $urandom};
            mid  = {$urandom, $urandom};
            hi   = $urandom;
            len  = 6'($urandom_range(REPORT_BYTES, MAX_LEN));
            pick = $urandom_range(0, 99);
            if (pick < 92) begin
                lo[7:0]  = 8'd0;
                lo[15:8] = 8'(REPORT_BYTES);
            end
            // face bytes straddling the threshold
            if (pick < 30) begin
                for (k = 4; k < 8; k++)
                    lo[8*k +: 8] = cfg_threshold + 8'($urandom_range(0, 2)) - 8'd1;
                for (k = 0; k < 2; k++)
                    mid[8*k +: 8] = cfg_threshold + 8'($urandom_range(0, 2)) - 8'd1;
            end
            if (pick >= 85 && pick < 92)
                len = 6'($urandom_range(0, REPORT_BYTES - 1));
            else if (pick >= 96)
                len = 6'($urandom);
            send_report(lo, mid, hi, len, 1'b0, '0);
        end
    endtask

    initial begin
        report_row_t   rows [$];
        decode_setup_t setups [SETUP_COUNT];
        int p;

        rows.push_back('{64'h0000_0000_0000_1400, 64'h0, 32'h0, 6'd20, 1'b1, BLANK_REPORT});
        rows.push_back('{64'hFFFF_FFFF_FFFF_1400, '1, '1, 6'd63, 1'b1, FULL_REPORT});
        // rejected: short transfers and bad header bytes
        rows.push_back('{64'h0000_0000_0000_1400, 64'h0, 32'h0, 6'd19, 1'b1, REJECTED});
        rows.push_back('{64'hFFFF_FFFF_FFFF_1400, '1, '1, 6'd0, 1'b1, REJECTED});
        rows.push_back('{64'h0000_0000_0000_1401, 64'h0, 32'h0, 6'd20, 1'b1, REJECTED});
        rows.push_back('{64'h0000_0000_0000_1500, 64'h0, 32'h0, 6'd20, 1'b1, REJECTED});
        rows.push_back('{64'h0000_0000_0000_1480, 64'h0, 32'h0, 6'd40, 1'b1, REJECTED});
        rows.push_back('{64'h0000_0000_0000_9400, 64'h0, 32'h0, 6'd40, 1'b1, REJECTED});
        rows.push_back('{64'h0000_0000_0000_0000, 64'h0, 32'h0, 6'd20, 1'b1, REJECTED});
        // single directions, opposite pairs and diagonals on the hat
        rows.push_back('{64'h0000_0000_0001_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_0002_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_0004_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_0008_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_0003_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_000C_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_0005_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_000A_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_0006_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        rows.push_back('{64'h0000_0000_0009_1400, 64'h0, 32'h0, 6'd20, 1'b0, '0});
        // digital buttons with the gun bit set while gun mode is off
        rows.push_back('{64'h0000_0000_20F0_1400, 64'h0, 32'h0, 6'd21, 1'b0, '0});
        // face bytes at and just above the threshold
        rows.push_back('{64'h2120_2021_0000_1400, 64'h0000_0000_0000_2120, 32'h0, 6'd20,
                         1'b0, '0});
        // stick words at and near their signed extremes
        rows.push_back('{64'h0000_0000_0000_1400, 64'h7FFF_8000_7F80_0000, 32'hFFFE_0001,
                         6'd32, 1'b0, '0});

        setups[0] = '{1'b1, 1'b0, 1'b0, 1'b0, 8'd32};
        setups[1] = '{1'b1, 1'b1, 1'b1, 1'b1, 8'h00};
        setups[2] = '{1'b1, 1'b0, 1'b1, 1'b0, 8'hFF};
        setups[3] = '{1'b0, 1'b1, 1'b1, 1'b0, 8'h80};
        setups[4] = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h7F};
        for (p = 5; p < SETUP_COUNT; p++)
            setups[p] = '{($urandom_range(0, 3) != 0), 1'($urandom), 1'($urandom),
                          1'($urandom), 8'($urandom)};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r])
            send_report(rows[r].lo, rows[r].mid, rows[r].hi, rows[r].len,
                        rows[r].known, rows[r].want);
        wait_drained();

        // the first setting keeps the reset values, the rest are written
        for (p = 0; p < SETUP_COUNT; p++) begin
            if (p > 0)
                apply_setup(setups[p]);
            steady_flow = (p == 2 || p == 5);
            random_reports(RANDOM_PER_SETUP);
            wait_drained();
        end

        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
